[hw/rtl/trcs_pkg.sv]
// ----------------------------------------------------------------------------
// trcs_pkg
// Types, constants and table functions for the three rotor cipher stepper.
// ----------------------------------------------------------------------------
package trcs_pkg;

	localparam int unsigned CFG_W       = 45;
	localparam int unsigned PLUG_W      = 130;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ASCII_A     = 8'd65;
	localparam logic [7:0] ASCII_Z     = 8'd90;
	localparam logic [7:0] ASCII_SPACE = 8'd32;
	localparam logic [4:0] LAST_LETTER = 5'd25;
	localparam logic [5:0] LETTERS     = 6'd26;
	localparam logic [2:0] GROUP_END   = 3'd4;
	localparam logic [2:0] ROTOR_V     = 3'd4;

	typedef enum logic [2:0] {
		REG_ROTOR_SELECT    = 3'd0,
		REG_RING_SETTINGS   = 3'd1,
		REG_START_POSITIONS = 3'd2,
		REG_REFLECTOR       = 3'd3,
		REG_GROUP_OUTPUT    = 3'd4,
		REG_PLUG_LOW        = 3'd5,
		REG_PLUG_MID        = 3'd6,
		REG_PLUG_HIGH       = 3'd7
	} trcs_reg_t;

	typedef struct packed {
		logic       ch_valid;
		logic       space_valid;
		logic [7:0] ch;
	} trcs_push_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} trcs_beat_t;

	localparam logic [8*26-1:0] WIRING_I   = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
	localparam logic [8*26-1:0] WIRING_II  = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
	localparam logic [8*26-1:0] WIRING_III = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
	localparam logic [8*26-1:0] WIRING_IV  = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
	localparam logic [8*26-1:0] WIRING_V   = "VZBRGITYUPSDNHLXAWMJQOFECK";
	localparam logic [8*26-1:0] REFLECT_B  = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
	localparam logic [8*26-1:0] REFLECT_C  = "FVPJIAOYEDRZXWGCTKUQSBNMHL";

	// letter x of a string table, first character at the top
	function automatic logic [4:0] tab_letter(logic [8*26-1:0] tab, logic [4:0] x);
		logic [7:0] ch;
		ch = tab[8*(25 - int'(x)) +: 8];
		return 5'(ch - ASCII_A);
	endfunction

	function automatic logic [2:0] rotor_code(logic [2:0] sel);
		return (sel > ROTOR_V) ? ROTOR_V : sel;
	endfunction

	function automatic logic [4:0] notch_of(logic [2:0] code);
		logic [4:0] n;
		unique case (code)
			3'd0:    n = 5'd16;
			3'd1:    n = 5'd4;
			3'd2:    n = 5'd21;
			3'd3:    n = 5'd9;
			default: n = 5'd25;
		endcase
		return n;
	endfunction

	function automatic logic [4:0] mod26(logic [4:0] v);
		return (v >= LETTERS[4:0]) ? 5'(v - LETTERS[4:0]) : v;
	endfunction

	function automatic logic [4:0] inc26(logic [4:0] v);
		return (v == LAST_LETTER) ? 5'd0 : 5'(v + 5'd1);
	endfunction

	function automatic logic [4:0] add26(logic [4:0] a, logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= LETTERS) ? 5'(s - LETTERS) : s[4:0];
	endfunction

	function automatic logic [4:0] sub26(logic [4:0] a, logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + LETTERS - {1'b0, b};
		return (a >= b) ? 5'(a - b) : s[4:0];
	endfunction

	function automatic logic [4:0] rotor_fwd(logic [2:0] code, logic [4:0] x);
		logic [4:0] y;
		unique case (code)
			3'd0:    y = tab_letter(WIRING_I, x);
			3'd1:    y = tab_letter(WIRING_II, x);
			3'd2:    y = tab_letter(WIRING_III, x);
			3'd3:    y = tab_letter(WIRING_IV, x);
			default: y = tab_letter(WIRING_V, x);
		endcase
		return y;
	endfunction

	// inverse wiring, folds into a constant table
	function automatic logic [4:0] rotor_bwd(logic [2:0] code, logic [4:0] x);
		logic [4:0] y;
		y = x;
		for (int i = 0; i < 26; i++) begin
			if (rotor_fwd(code, 5'(i)) == x) begin
				y = 5'(i);
			end
		end
		return y;
	endfunction

	function automatic logic [4:0] reflect(logic choice, logic [4:0] x);
		return choice ? tab_letter(REFLECT_C, x) : tab_letter(REFLECT_B, x);
	endfunction

	// entry holds partner plus one, zero or out of range leaves the letter alone
	function automatic logic [4:0] plug(logic [PLUG_W-1:0] board, logic [4:0] c);
		logic [4:0] e;
		e = board[5*int'(c) +: 5];
		return (e >= 5'd1 && e <= LETTERS[4:0]) ? 5'(e - 5'd1) : c;
	endfunction

	function automatic logic [4:0] rotor_pass(logic [4:0] c, logic [2:0] sel,
			logic [4:0] ring, logic [4:0] pos, logic back);
		logic [2:0] code;
		logic [4:0] shift;
		logic [4:0] x;
		logic [4:0] y;
		code  = rotor_code(sel);
		shift = sub26(pos, mod26(ring));
		x     = add26(c, shift);
		y     = back ? rotor_bwd(code, x) : rotor_fwd(code, x);
		return sub26(y, shift);
	endfunction

endpackage

[hw/rtl/trcs_channels_if.sv]
// ----------------------------------------------------------------------------
// trcs channels
// Valid/ready channels for input bytes and cipher result beats.
// ----------------------------------------------------------------------------
interface trcs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       new_message;

	modport source(output valid, output char_in, output new_message, input ready);
	modport sink(input valid, input char_in, input new_message, output ready);
endinterface

interface trcs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last;

	modport source(output valid, output char_out, output last, input ready);
	modport sink(input valid, input char_out, input last, output ready);
endinterface

[hw/rtl/trcs_out_queue.sv]
// ----------------------------------------------------------------------------
// trcs_out_queue
// Small result queue that takes up to two beats a cycle and hands out one while the result side is ready.
// ----------------------------------------------------------------------------
module trcs_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  trcs_pkg::trcs_push_t push,
	output logic                room,
	trcs_out_if.source          result
);

	trcs_pkg::trcs_beat_t mem_q [trcs_pkg::QUEUE_DEPTH];
	logic [trcs_pkg::QPTR_W-1:0] wptr_q;
	logic [trcs_pkg::QPTR_W-1:0] rptr_q;
	logic [trcs_pkg::QCNT_W-1:0] count_q;
	logic [trcs_pkg::QPTR_W-1:0] wptr_next;
	logic [trcs_pkg::QCNT_W-1:0] npush;
	logic                        pop;

	assign pop       = (count_q != '0) && result.ready;
	assign wptr_next = trcs_pkg::QPTR_W'(wptr_q + 1'b1);
	assign npush     = trcs_pkg::QCNT_W'(push.ch_valid) + trcs_pkg::QCNT_W'(push.space_valid);
	// space for the two beats one item can leave
	assign room      = count_q <= trcs_pkg::QCNT_W'(trcs_pkg::QUEUE_DEPTH - 2);

	assign result.valid    = count_q != '0;
	assign result.char_out = mem_q[rptr_q].ch;
	assign result.last     = mem_q[rptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= trcs_pkg::QPTR_W'(wptr_q + npush);
			rptr_q  <= trcs_pkg::QPTR_W'(rptr_q + pop);
			count_q <= trcs_pkg::QCNT_W'(count_q + npush - trcs_pkg::QCNT_W'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push.ch_valid) begin
			mem_q[wptr_q] <= '{ch: push.ch, last: !push.space_valid};
		end
		if (push.space_valid) begin
			mem_q[wptr_next] <= '{ch: trcs_pkg::ASCII_SPACE, last: 1'b1};
		end
	end

endmodule

[hw/rtl/three_rotor_cipher_stepper.sv]
// ----------------------------------------------------------------------------
// three_rotor_cipher_stepper
// Three rotor cipher with plugboard, B or C reflector and five letter grouping.
// ----------------------------------------------------------------------------
// Takes one byte per clock while input ready is high. Rotor stepping,
// including the double step of the middle rotor, is resolved at the accepting
// edge, so the next byte may follow at once. The letter then runs through two
// register stages (plugboard and forward rotors up to the reflector, then
// inverse rotors and plugboard) into a four beat result queue, which takes
// the letter from stage 2. A grouping space costs one extra output beat, and
// input ready drops while the queue holds more than two beats. Spaces are
// echoed only with grouping off; other bytes give no beat. Configuration may
// only be written while nothing is in flight.
module three_rotor_cipher_stepper (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [trcs_pkg::CFG_W-1:0] cfg_data,
	trcs_in_if.sink                   char_stream,
	trcs_out_if.source                cipher_stream
);

	// configuration
	logic [8:0]  rotor_select_q;
	logic [14:0] ring_settings_q;
	logic [14:0] start_positions_q;
	logic        reflector_q;
	logic        group_output_q;
	logic [44:0] plug_low_q;
	logic [44:0] plug_mid_q;
	logic [39:0] plug_high_q;
	logic [trcs_pkg::PLUG_W-1:0] board;

	// rotor and group state
	logic [4:0] left_q, mid_q, right_q;
	logic [2:0] group_q;

	logic       advance;
	logic       take;
	logic       is_letter, is_echo, space_after;
	logic [4:0] left_base, mid_base, right_base;
	logic [4:0] left_next, mid_next, right_next;
	logic [2:0] group_base, group_next;
	logic       mid_notch, right_notch;

	// stage 1: entering letter and stepped positions
	logic       valid_s1, letter_s1, echo_s1, space_s1;
	logic [4:0] c_s1, left_s1, mid_s1, right_s1;
	// stage 2: reflected letter
	logic       valid_s2, letter_s2, echo_s2, space_s2;
	logic [4:0] c_s2, left_s2, mid_s2, right_s2;

	logic [4:0] fwd_c;
	logic [4:0] bwd_c;
	trcs_pkg::trcs_push_t push;
	logic       room;

	assign board = {plug_high_q, plug_mid_q, plug_low_q};

	assign advance           = room;
	assign char_stream.ready = advance;
	assign take              = char_stream.valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_select_q    <= 9'd10;
			ring_settings_q   <= '0;
			start_positions_q <= '0;
			reflector_q       <= 1'b0;
			group_output_q    <= 1'b1;
			plug_low_q        <= '0;
			plug_mid_q        <= '0;
			plug_high_q       <= '0;
		end else if (cfg_we) begin
			unique case (trcs_pkg::trcs_reg_t'(cfg_index))
				trcs_pkg::REG_ROTOR_SELECT:    rotor_select_q    <= cfg_data[8:0];
				trcs_pkg::REG_RING_SETTINGS:   ring_settings_q   <= cfg_data[14:0];
				trcs_pkg::REG_START_POSITIONS: start_positions_q <= cfg_data[14:0];
				trcs_pkg::REG_REFLECTOR:       reflector_q       <= cfg_data[0];
				trcs_pkg::REG_GROUP_OUTPUT:    group_output_q    <= cfg_data[0];
				trcs_pkg::REG_PLUG_LOW:        plug_low_q        <= cfg_data[44:0];
				trcs_pkg::REG_PLUG_MID:        plug_mid_q        <= cfg_data[44:0];
				trcs_pkg::REG_PLUG_HIGH:       plug_high_q       <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	// stepping is settled on the accepting edge
	always_comb begin
		is_letter = (char_stream.char_in >= trcs_pkg::ASCII_A)
			&& (char_stream.char_in <= trcs_pkg::ASCII_Z);
		is_echo   = (char_stream.char_in == trcs_pkg::ASCII_SPACE) && !group_output_q;

		if (char_stream.new_message) begin
			left_base  = trcs_pkg::mod26(start_positions_q[14:10]);
			mid_base   = trcs_pkg::mod26(start_positions_q[9:5]);
			right_base = trcs_pkg::mod26(start_positions_q[4:0]);
			group_base = '0;
		end else begin
			left_base  = left_q;
			mid_base   = mid_q;
			right_base = right_q;
			group_base = group_q;
		end

		mid_notch   = mid_base ==
			trcs_pkg::notch_of(trcs_pkg::rotor_code(rotor_select_q[5:3]));
		right_notch = right_base ==
			trcs_pkg::notch_of(trcs_pkg::rotor_code(rotor_select_q[2:0]));

		left_next   = left_base;
		mid_next    = mid_base;
		right_next  = right_base;
		group_next  = group_base;
		space_after = 1'b0;
		if (is_letter) begin
			// double step: the middle rotor moves on its own notch as well
			if (mid_notch) begin
				left_next = trcs_pkg::inc26(left_base);
			end
			if (mid_notch || right_notch) begin
				mid_next = trcs_pkg::inc26(mid_base);
			end
			right_next  = trcs_pkg::inc26(right_base);
			group_next  = (group_base == trcs_pkg::GROUP_END) ? 3'd0 : 3'(group_base + 3'd1);
			space_after = (group_next == 3'd0) && group_output_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			mid_q    <= '0;
			right_q  <= '0;
			group_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			if (take) begin
				left_q  <= left_next;
				mid_q   <= mid_next;
				right_q <= right_next;
				group_q <= group_next;
			end
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			letter_s1 <= is_letter;
			echo_s1   <= is_echo;
			space_s1  <= space_after;
			c_s1      <= 5'(char_stream.char_in - trcs_pkg::ASCII_A);
			left_s1   <= left_next;
			mid_s1    <= mid_next;
			right_s1  <= right_next;

			letter_s2 <= letter_s1;
			echo_s2   <= echo_s1;
			space_s2  <= space_s1;
			c_s2      <= fwd_c;
			left_s2   <= left_s1;
			mid_s2    <= mid_s1;
			right_s2  <= right_s1;
		end
	end

	// plugboard, forward rotors, reflector
	always_comb begin
		logic [4:0] c;
		c     = trcs_pkg::plug(board, c_s1);
		c     = trcs_pkg::rotor_pass(c, rotor_select_q[2:0], ring_settings_q[4:0],
			right_s1, 1'b0);
		c     = trcs_pkg::rotor_pass(c, rotor_select_q[5:3], ring_settings_q[9:5],
			mid_s1, 1'b0);
		c     = trcs_pkg::rotor_pass(c, rotor_select_q[8:6], ring_settings_q[14:10],
			left_s1, 1'b0);
		fwd_c = trcs_pkg::reflect(reflector_q, c);
	end

	// inverse rotors and plugboard
	always_comb begin
		logic [4:0] c;
		c     = trcs_pkg::rotor_pass(c_s2, rotor_select_q[8:6], ring_settings_q[14:10],
			left_s2, 1'b1);
		c     = trcs_pkg::rotor_pass(c, rotor_select_q[5:3], ring_settings_q[9:5],
			mid_s2, 1'b1);
		c     = trcs_pkg::rotor_pass(c, rotor_select_q[2:0], ring_settings_q[4:0],
			right_s2, 1'b1);
		bwd_c = trcs_pkg::plug(board, c);
	end

	always_comb begin
		push.ch_valid    = advance && valid_s2 && (letter_s2 || echo_s2);
		push.space_valid = advance && valid_s2 && space_s2;
		push.ch          = letter_s2 ? (trcs_pkg::ASCII_A + 8'(bwd_c)) : trcs_pkg::ASCII_SPACE;
	end

	trcs_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (cipher_stream)
	);

endmodule

[hw/rtl/trcs_checker.sv]
// ----------------------------------------------------------------------------
// trcs_checker
// Port level checks on the cipher result channel.
// ----------------------------------------------------------------------------
module trcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last
);

	// only letters and spaces leave the block
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == 8'd32) || ((out_char >= 8'd65) && (out_char <= 8'd90)))
		else $error("result beat is neither letter nor space");

	// a space is always the final beat of its byte
	a_space_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_char == 8'd32) |-> out_last)
		else $error("space beat without last");

	// a letter with a grouping space behind it offers the space next cycle
	a_group_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=> (out_valid && out_char == 8'd32))
		else $error("grouping space not ready after its letter");

	// nothing offered while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered during reset");

endmodule

bind three_rotor_cipher_stepper trcs_checker u_trcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (cipher_stream.valid),
	.out_ready (cipher_stream.ready),
	.out_char  (cipher_stream.char_out),
	.out_last  (cipher_stream.last)
);
